>>> hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared widths, status codes, the request record passed from the parser to
// the output sequencer, and the length helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int LENGTH_BITS  = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  // Result status codes.
  localparam logic [3:0] ST_RUNNING        = 4'd0;
  localparam logic [3:0] ST_COMPLETE       = 4'd1;
  localparam logic [3:0] ST_QUOTE_REQUIRED = 4'd2;
  localparam logic [3:0] ST_CONTROL_BYTE   = 4'd3;
  localparam logic [3:0] ST_ESC_TRUNC      = 4'd4;
  localparam logic [3:0] ST_ESC_INVALID    = 4'd5;
  localparam logic [3:0] ST_HEX_TRUNC      = 4'd6;
  localparam logic [3:0] ST_HEX_INVALID    = 4'd7;
  localparam logic [3:0] ST_SURR_INCOMPL   = 4'd8;
  localparam logic [3:0] ST_SURR_INVALID   = 4'd9;
  localparam logic [3:0] ST_BAD_UTF8       = 4'd10;
  localparam logic [3:0] ST_STR_TRUNC      = 4'd11;

  // One parsed input byte: up to four decoded bytes, or one status result.
  typedef struct packed {
    logic [3:0][7:0]         bytes;
    logic [2:0]              nbytes;
    logic                    has_status;
    logic [3:0]              status;
    logic [LENGTH_BITS-1:0]  base_len;
  } jsu_rec_t;

  function automatic logic [LENGTH_BITS-1:0] len_sat_add(
      input logic [LENGTH_BITS-1:0] base,
      input logic [2:0]             k);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, base} + (LENGTH_BITS + 1)'(k);
    if (s > {1'b0, LenMax}) begin
      return LenMax;
    end
    return s[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [15:0] len_show(input logic [LENGTH_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    if (w > 33'h0FFFF) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

>>> hw/rtl/json_string_unescape_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape top level
// Decodes one JSON string from a byte stream into UTF-8 bytes with status.
// ----------------------------------------------------------------------------
// The parser takes one input request per cycle while the queue is not full
// and turns it into a record of zero to four decoded bytes or one status
// result. Records wait in a four-entry queue, and the output side sends one
// result per cycle unless the output is stalled, from the queue head
// through an output register. Input is stalled only while the queue is full,
// which happens when multi-byte results (up to four per input byte, from a
// \u escape or a completed raw UTF-8 sequence) arrive faster than the output
// drains them or the output is stalled. An end-of-input request reports any
// unfinished string and returns the parser to its reset state.
module json_string_unescape_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_opcode,
  input  logic [7:0]   in_in_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_out_byte,
  output logic         out_byte_valid,
  output logic         out_last,
  output logic [3:0]   out_status,
  output logic [15:0]  out_decoded_length
);
  import jsu_pkg::*;

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  jsu_rec_t  q_rec;
  jsu_rec_t  q_head;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_in_byte (in_in_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_rec)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  jsu_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length)
  );

endmodule

>>> hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape parser
// Accepts one input request per cycle while the output queue is not full,
// parses it into one record of decoded bytes or a status for that queue.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [7:0]          in_in_byte,
  input  logic                q_full,
  output logic                q_push,
  output jsu_pkg::jsu_rec_t   q_rec
);
  import jsu_pkg::*;

  localparam logic [3:0] PH_SEEK     = 4'd0;
  localparam logic [3:0] PH_TEXT     = 4'd1;
  localparam logic [3:0] PH_ESC      = 4'd2;
  localparam logic [3:0] PH_HEX1     = 4'd3;
  localparam logic [3:0] PH_HEX1_BAD = 4'd4;
  localparam logic [3:0] PH_WANT_BS  = 4'd5;
  localparam logic [3:0] PH_WANT_U   = 4'd6;
  localparam logic [3:0] PH_HEX2     = 4'd7;
  localparam logic [3:0] PH_UTF8     = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;
  localparam logic [3:0] PH_ERROR    = 4'd10;

  logic [3:0]             phase_r, phase_nxt;
  logic [15:0]            acc_r, acc_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic [9:0]             hs_r, hs_nxt;
  logic [1:0]             need_r, need_nxt;
  logic [1:0]             seen_r, seen_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [7:0]             held_r [3];
  logic                   held_we;
  logic [1:0]             held_idx;

  logic                   accept;
  logic [7:0]             b;
  logic [4:0]             hex;
  logic [15:0]            acc_sh;
  logic                   hex_bad;
  logic                   cp_emit;
  logic [20:0]            cp_val;
  jsu_rec_t               rec;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      return {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      return {1'b0, 4'(c - 8'h37)};
    end
    return 5'h10;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;
  assign b        = in_in_byte;
  assign hex      = hex_val(in_in_byte);
  assign acc_sh   = {acc_r[11:0], hex[3:0]};
  assign q_push   = accept && (rec.has_status || (rec.nbytes != 3'd0));
  assign q_rec    = rec;

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    hs_nxt       = hs_r;
    need_nxt     = need_r;
    seen_nxt     = seen_r;
    held_we      = 1'b0;
    held_idx     = seen_r;
    cp_emit      = 1'b0;
    cp_val       = '0;
    hex_bad      = 1'b0;
    rec          = '0;
    rec.base_len = len_r;

    if (in_opcode) begin
      rec.has_status = 1'b1;
      case (phase_r)
        PH_SEEK:                 rec.status = ST_QUOTE_REQUIRED;
        PH_TEXT:                 rec.status = ST_STR_TRUNC;
        PH_ESC:                  rec.status = ST_ESC_TRUNC;
        PH_HEX1, PH_HEX1_BAD:    rec.status = ST_HEX_TRUNC;
        PH_WANT_BS, PH_WANT_U:   rec.status = ST_SURR_INCOMPL;
        PH_HEX2:                 rec.status = ST_SURR_INVALID;
        PH_UTF8:                 rec.status = ST_BAD_UTF8;
        default: begin
          rec.has_status = 1'b0;
          rec.status     = ST_RUNNING;
        end
      endcase
      phase_nxt = PH_SEEK;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      hs_nxt    = '0;
      need_nxt  = '0;
      seen_nxt  = '0;
    end else begin
      case (phase_r)
        PH_SEEK: begin
          if (b inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
            phase_nxt = PH_SEEK;
          end else if (b == 8'h22) begin
            phase_nxt = PH_TEXT;
          end else begin
            rec.has_status = 1'b1;
            rec.status     = ST_QUOTE_REQUIRED;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_TEXT: begin
          if (b == 8'h22) begin
            rec.has_status = 1'b1;
            rec.status     = ST_COMPLETE;
            phase_nxt      = PH_DONE;
          end else if (b < 8'h20) begin
            rec.has_status = 1'b1;
            rec.status     = ST_CONTROL_BYTE;
            phase_nxt      = PH_ERROR;
          end else if (b == 8'h5C) begin
            phase_nxt = PH_ESC;
          end else if (b < 8'h80) begin
            rec.bytes[0] = b;
            rec.nbytes   = 3'd1;
          end else if (b inside {[8'hC2:8'hF4]}) begin
            if (b inside {[8'hC2:8'hDF]}) begin
              need_nxt = 2'd1;
            end else if (b inside {[8'hE0:8'hEF]}) begin
              need_nxt = 2'd2;
            end else begin
              need_nxt = 2'd3;
            end
            held_we   = 1'b1;
            held_idx  = 2'd0;
            seen_nxt  = 2'd1;
            phase_nxt = PH_UTF8;
          end else begin
            rec.has_status = 1'b1;
            rec.status     = ST_BAD_UTF8;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_ESC: begin
          phase_nxt  = PH_TEXT;
          rec.nbytes = 3'd1;
          case (b)
            8'h22, 8'h5C, 8'h2F: rec.bytes[0] = b;
            8'h62:               rec.bytes[0] = 8'h08;
            8'h66:               rec.bytes[0] = 8'h0C;
            8'h6E:               rec.bytes[0] = 8'h0A;
            8'h72:               rec.bytes[0] = 8'h0D;
            8'h74:               rec.bytes[0] = 8'h09;
            8'h75: begin
              rec.nbytes = 3'd0;
              phase_nxt  = PH_HEX1;
              acc_nxt    = '0;
              cnt_nxt    = '0;
            end
            default: begin
              rec.nbytes     = 3'd0;
              rec.has_status = 1'b1;
              rec.status     = ST_ESC_INVALID;
              phase_nxt      = PH_ERROR;
            end
          endcase
        end
        PH_HEX1, PH_HEX1_BAD: begin
          hex_bad = (phase_r == PH_HEX1_BAD) || hex[4];
          acc_nxt = acc_sh;
          if (cnt_r != 2'd3) begin
            cnt_nxt   = cnt_r + 2'd1;
            phase_nxt = hex_bad ? PH_HEX1_BAD : PH_HEX1;
          end else begin
            cnt_nxt = '0;
            if (hex_bad) begin
              rec.has_status = 1'b1;
              rec.status     = ST_HEX_INVALID;
              phase_nxt      = PH_ERROR;
            end else if (acc_sh inside {[16'hD800:16'hDBFF]}) begin
              hs_nxt    = acc_sh[9:0];
              phase_nxt = PH_WANT_BS;
            end else if (acc_sh inside {[16'hDC00:16'hDFFF]}) begin
              rec.has_status = 1'b1;
              rec.status     = ST_SURR_INVALID;
              phase_nxt      = PH_ERROR;
            end else begin
              phase_nxt = PH_TEXT;
              cp_emit   = 1'b1;
              cp_val    = {5'd0, acc_sh};
            end
          end
        end
        PH_WANT_BS: begin
          if (b == 8'h5C) begin
            phase_nxt = PH_WANT_U;
          end else begin
            rec.has_status = 1'b1;
            rec.status     = ST_SURR_INCOMPL;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_WANT_U: begin
          if (b == 8'h75) begin
            phase_nxt = PH_HEX2;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            rec.has_status = 1'b1;
            rec.status     = ST_SURR_INCOMPL;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_HEX2: begin
          if (hex[4]) begin
            rec.has_status = 1'b1;
            rec.status     = ST_SURR_INVALID;
            phase_nxt      = PH_ERROR;
          end else begin
            acc_nxt = acc_sh;
            if (cnt_r != 2'd3) begin
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              cnt_nxt = '0;
              if (!(acc_sh inside {[16'hDC00:16'hDFFF]})) begin
                rec.has_status = 1'b1;
                rec.status     = ST_SURR_INVALID;
                phase_nxt      = PH_ERROR;
              end else begin
                phase_nxt = PH_TEXT;
                cp_emit   = 1'b1;
                cp_val    = 21'h10000 + {1'b0, hs_r, acc_sh[9:0]};
              end
            end
          end
        end
        PH_UTF8: begin
          if ((b & 8'hC0) != 8'h80) begin
            rec.has_status = 1'b1;
            rec.status     = ST_BAD_UTF8;
            phase_nxt      = PH_ERROR;
          end else if ((seen_r == 2'd1) &&
                       (((held_r[0] == 8'hE0) && (b < 8'hA0)) ||
                        ((held_r[0] == 8'hED) && (b >= 8'hA0)) ||
                        ((held_r[0] == 8'hF0) && (b < 8'h90)) ||
                        ((held_r[0] == 8'hF4) && (b >= 8'h90)))) begin
            rec.has_status = 1'b1;
            rec.status     = ST_BAD_UTF8;
            phase_nxt      = PH_ERROR;
          end else if (seen_r < need_r) begin
            held_we  = 1'b1;
            held_idx = seen_r;
            seen_nxt = seen_r + 2'd1;
          end else begin
            // The held bytes go out in order, followed by this byte.
            rec.bytes[0]      = held_r[0];
            rec.bytes[1]      = held_r[1];
            rec.bytes[2]      = held_r[2];
            rec.bytes[seen_r] = b;
            rec.nbytes        = {1'b0, seen_r} + 3'd1;
            seen_nxt          = '0;
            need_nxt          = '0;
            phase_nxt         = PH_TEXT;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    if (cp_emit) begin
      if (cp_val <= 21'h7F) begin
        rec.bytes[0] = cp_val[7:0];
        rec.nbytes   = 3'd1;
      end else if (cp_val <= 21'h7FF) begin
        rec.bytes[0] = {3'b110, cp_val[10:6]};
        rec.bytes[1] = {2'b10, cp_val[5:0]};
        rec.nbytes   = 3'd2;
      end else if (cp_val <= 21'hFFFF) begin
        rec.bytes[0] = {4'b1110, cp_val[15:12]};
        rec.bytes[1] = {2'b10, cp_val[11:6]};
        rec.bytes[2] = {2'b10, cp_val[5:0]};
        rec.nbytes   = 3'd3;
      end else begin
        rec.bytes[0] = {5'b11110, cp_val[20:18]};
        rec.bytes[1] = {2'b10, cp_val[17:12]};
        rec.bytes[2] = {2'b10, cp_val[11:6]};
        rec.bytes[3] = {2'b10, cp_val[5:0]};
        rec.nbytes   = 3'd4;
      end
    end

    len_nxt = in_opcode ? '0 : len_sat_add(len_r, rec.nbytes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      acc_r   <= '0;
      cnt_r   <= '0;
      hs_r    <= '0;
      need_r  <= '0;
      seen_r  <= '0;
      len_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hs_r    <= hs_nxt;
      need_r  <= need_nxt;
      seen_r  <= seen_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[held_idx] <= b;
    end
  end

endmodule

>>> hw/rtl/jsu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape record queue
// Small register FIFO of parser records between the parser and the output
// sequencer.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_rec_t   push_rec,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output jsu_pkg::jsu_rec_t   head
);
  import jsu_pkg::*;

  jsu_rec_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QCNT_BITS-1:0]   cnt_r;

  assign full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape output sequencer
// Walks the queue head record into the output register one result per
// cycle unless the output stalls, and pops it after its last result.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  jsu_pkg::jsu_rec_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_out_byte,
  output logic                out_byte_valid,
  output logic                out_last,
  output logic [3:0]          out_status,
  output logic [15:0]         out_decoded_length
);
  import jsu_pkg::*;

  logic [2:0]   idx_r;
  logic         valid_r;
  logic [7:0]   byte_r;
  logic         bvalid_r;
  logic         last_r;
  logic [3:0]   status_r;
  logic [15:0]  len_r;

  logic         load;
  logic [2:0]   total;
  logic         is_byte;
  logic         is_last;

  assign total   = q_head.nbytes + {2'b00, q_head.has_status};
  assign is_byte = (idx_r < q_head.nbytes);
  assign is_last = (idx_r == total - 3'd1);
  assign load    = !q_empty && (!valid_r || !out_stall);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 3'd0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      if (is_byte) begin
        byte_r   <= q_head.bytes[idx_r[1:0]];
        bvalid_r <= 1'b1;
        status_r <= ST_RUNNING;
        len_r    <= len_show(len_sat_add(q_head.base_len, idx_r + 3'd1));
      end else begin
        byte_r   <= 8'h00;
        bvalid_r <= 1'b0;
        status_r <= q_head.status;
        len_r    <= len_show(q_head.base_len);
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_out_byte       = byte_r;
  assign out_byte_valid     = bvalid_r;
  assign out_last           = last_r;
  assign out_status         = status_r;
  assign out_decoded_length = len_r;

endmodule
